// ===== rtl/mdcs_pkg.sv =====
// Shared types, constants and register codes of the mouse delta coalesce and scale block.
package mdcs_pkg;

  localparam int OFS_W       = 8;
  localparam int VAL_W       = 32;
  localparam int STAMP_W     = 32;
  localparam int MULT_W      = 23;
  localparam int KEPT_W      = 16;
  localparam int CFG_DATA_W  = 23;
  localparam int CFG_INDEX_W = 3;

  localparam int FRAC_BITS_DEFAULT   = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [KEPT_W-1:0]       KEPT_MAX = 16'hFFFF;

  localparam logic              RST_COALESCE = 1'b1;
  localparam logic [MULT_W-1:0] RST_MULT     = 23'd65536;
  localparam logic [OFS_W-1:0]  RST_X_OFS    = 8'd0;
  localparam logic [OFS_W-1:0]  RST_Y_OFS    = 8'd4;
  localparam logic              RST_X_PRES   = 1'b1;
  localparam logic              RST_Y_PRES   = 1'b1;
  localparam logic [KEPT_W-1:0] RST_CAPACITY = 16'd64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COALESCE_ENABLE = 3'd0,
    REG_MULTIPLIER_X    = 3'd1,
    REG_MULTIPLIER_Y    = 3'd2,
    REG_X_AXIS_OFFSET   = 3'd3,
    REG_Y_AXIS_OFFSET   = 3'd4,
    REG_X_AXIS_PRESENT  = 3'd5,
    REG_Y_AXIS_PRESENT  = 3'd6,
    REG_BATCH_CAPACITY  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              coalesce_enable;
    logic [MULT_W-1:0] multiplier_x;
    logic [MULT_W-1:0] multiplier_y;
    logic [OFS_W-1:0]  x_axis_offset;
    logic [OFS_W-1:0]  y_axis_offset;
    logic              x_axis_present;
    logic              y_axis_present;
    logic [KEPT_W-1:0] batch_capacity;
  } cfg_t;

  typedef struct packed {
    logic [OFS_W-1:0]        event_offset;
    logic signed [VAL_W-1:0] event_value;
    logic [STAMP_W-1:0]      time_stamp;
    logic [STAMP_W-1:0]      sequence_number;
    logic                    batch_last;
  } in_item_t;

  typedef struct packed {
    logic [OFS_W-1:0]        out_offset;
    logic signed [VAL_W-1:0] out_value;
    logic [STAMP_W-1:0]      out_stamp;
    logic [STAMP_W-1:0]      out_sequence;
    logic                    out_present;
    logic                    out_batch_end;
  } out_item_t;

  // What the back end does with the event of a queued job.
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PASS    = 2'd1,
    KIND_SCALE_X = 2'd2,
    KIND_SCALE_Y = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [OFS_W-1:0]        ofs;
    logic signed [VAL_W-1:0] val;
    logic [STAMP_W-1:0]      stamp;
    logic [STAMP_W-1:0]      seq;
    logic                    last;
    logic                    seen_x;
    logic                    seen_y;
    logic signed [VAL_W-1:0] sum_x;
    logic signed [VAL_W-1:0] sum_y;
    logic [STAMP_W-1:0]      stamp_x;
    logic [STAMP_W-1:0]      seq_x;
    logic [STAMP_W-1:0]      stamp_y;
    logic [STAMP_W-1:0]      seq_y;
  } job_t;

endpackage

// ===== rtl/mdcs_if.sv =====
// Valid/ready stream interfaces for the input events and the result events.
interface mdcs_in_if import mdcs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mdcs_out_if import mdcs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mdcs_front.sv =====
// Front end: classifies each event, gathers the batch sums and queues jobs.
module mdcs_front import mdcs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_ready,
  output logic     push_valid,
  output job_t     push_job,
  input  logic     push_ready
);

  logic signed [VAL_W-1:0] sum_x, sum_y;
  logic signed [VAL_W-1:0] sum_x_next, sum_y_next;
  logic                    seen_x, seen_y;
  logic                    seen_x_next, seen_y_next;
  logic [STAMP_W-1:0]      stamp_x, seq_x, stamp_y, seq_y;
  logic [STAMP_W-1:0]      stamp_x_next, seq_x_next, stamp_y_next, seq_y_next;
  logic                    mx, my, scaling, accept;
  kind_t                   kind;

  function automatic logic signed [VAL_W-1:0] sat_add(logic signed [VAL_W-1:0] a,
                                                      logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

  always_comb begin
    mx = cfg.x_axis_present && (in_data.event_offset == cfg.x_axis_offset);
    my = !mx && cfg.y_axis_present && (in_data.event_offset == cfg.y_axis_offset);
    // Both gains at exactly one leave in-place events untouched.
    scaling = (32'(cfg.multiplier_x) != (32'(1) << FRAC_BITS)) ||
              (32'(cfg.multiplier_y) != (32'(1) << FRAC_BITS));

    sum_x_next   = sum_x;
    sum_y_next   = sum_y;
    seen_x_next  = seen_x;
    seen_y_next  = seen_y;
    stamp_x_next = stamp_x;
    seq_x_next   = seq_x;
    stamp_y_next = stamp_y;
    seq_y_next   = seq_y;

    if (cfg.coalesce_enable) begin
      if (mx) begin
        sum_x_next   = sat_add(sum_x, in_data.event_value);
        seen_x_next  = 1'b1;
        stamp_x_next = in_data.time_stamp;
        seq_x_next   = in_data.sequence_number;
        kind         = KIND_NONE;
      end else if (my) begin
        sum_y_next   = sat_add(sum_y, in_data.event_value);
        seen_y_next  = 1'b1;
        stamp_y_next = in_data.time_stamp;
        seq_y_next   = in_data.sequence_number;
        kind         = KIND_NONE;
      end else begin
        kind = KIND_PASS;
      end
    end else if (scaling && mx) begin
      kind = KIND_SCALE_X;
    end else if (scaling && my) begin
      kind = KIND_SCALE_Y;
    end else begin
      kind = KIND_PASS;
    end

    push_job.kind    = kind;
    push_job.ofs     = in_data.event_offset;
    push_job.val     = in_data.event_value;
    push_job.stamp   = in_data.time_stamp;
    push_job.seq     = in_data.sequence_number;
    push_job.last    = in_data.batch_last;
    push_job.seen_x  = seen_x_next;
    push_job.seen_y  = seen_y_next;
    push_job.sum_x   = sum_x_next;
    push_job.sum_y   = sum_y_next;
    push_job.stamp_x = stamp_x_next;
    push_job.seq_x   = seq_x_next;
    push_job.stamp_y = stamp_y_next;
    push_job.seq_y   = seq_y_next;
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && push_ready;
  // A coalesced axis event in mid-batch only updates the sums.
  assign push_valid = accept && ((kind != KIND_NONE) || in_data.batch_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x  <= '0;
      sum_y  <= '0;
      seen_x <= 1'b0;
      seen_y <= 1'b0;
    end else if (accept) begin
      if (in_data.batch_last) begin
        sum_x  <= '0;
        sum_y  <= '0;
        seen_x <= 1'b0;
        seen_y <= 1'b0;
      end else begin
        sum_x   <= sum_x_next;
        sum_y   <= sum_y_next;
        seen_x  <= seen_x_next;
        seen_y  <= seen_y_next;
        stamp_x <= stamp_x_next;
        seq_x   <= seq_x_next;
        stamp_y <= stamp_y_next;
        seq_y   <= seq_y_next;
      end
    end
  end

endmodule

// ===== rtl/mdcs_queue.sv =====
// Short job queue between the front end and the back end.
module mdcs_queue import mdcs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  job_t push_job,
  output logic push_ready,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop_ready
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/mdcs_back.sv =====
// Back end: scales with the shared multiplier, keeps the remainders and orders the results.
module mdcs_back import mdcs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_ready
);

  localparam int PROD_W = VAL_W + MULT_W + 1;
  localparam int TOT_W  = PROD_W + 1;
  localparam int FL_W   = TOT_W - FRAC_BITS;
  localparam int WH_W   = FL_W + 1;
  localparam int FR_W   = FRAC_BITS + 1;
  localparam logic signed [WH_W-1:0] WH_MAX = WH_W'(VAL_MAX);
  localparam logic signed [WH_W-1:0] WH_MIN = WH_W'(VAL_MIN);

  typedef enum logic [2:0] {
    ST_HEAD,
    ST_FIX,
    ST_X,
    ST_Y,
    ST_END
  } state_t;

  state_t                   state;
  logic signed [PROD_W-1:0] prod;
  logic                     op_y, op_flush;
  logic signed [FR_W-1:0]   frac_x, frac_y;
  logic [KEPT_W-1:0]        kept;
  out_item_t                pend;
  logic                     pend_v;
  out_item_t                out_q;
  logic                     out_v;

  logic signed [VAL_W-1:0]  mul_a;
  logic [MULT_W-1:0]        mul_b;
  logic signed [PROD_W-1:0] mul_a_ext, mul_b_ext, mul_p;
  logic signed [FR_W-1:0]   frac_sel, frac_new;
  logic signed [TOT_W-1:0]  total;
  logic signed [FL_W-1:0]   fl;
  logic [FRAC_BITS-1:0]     low;
  logic                     inc, ovf;
  logic signed [WH_W-1:0]   whole;
  logic signed [VAL_W-1:0]  scaled;
  logic                     out_free, stall, prod_req, prod_fire, end_go;
  out_item_t                prod_item, marker;
  logic [KEPT_W-1:0]        kept_inc;

  always_comb begin
    unique case (state)
      ST_X: begin
        mul_a = head.sum_x;
        mul_b = cfg.multiplier_x;
      end
      ST_Y: begin
        mul_a = head.sum_y;
        mul_b = cfg.multiplier_y;
      end
      default: begin
        mul_a = head.val;
        mul_b = (head.kind == KIND_SCALE_Y) ? cfg.multiplier_y : cfg.multiplier_x;
      end
    endcase
    mul_a_ext = PROD_W'(mul_a);
    mul_b_ext = signed'(PROD_W'(mul_b));
    mul_p     = mul_a_ext * mul_b_ext;
  end

  // Truncation toward zero is the floor plus one for a negative total with a
  // nonzero fraction; the remainder is then the low bits less one unit.
  always_comb begin
    frac_sel = op_y ? frac_y : frac_x;
    total    = TOT_W'(prod) + TOT_W'(frac_sel);
    fl       = total[TOT_W-1:FRAC_BITS];
    low      = total[FRAC_BITS-1:0];
    inc      = total[TOT_W-1] && (low != '0);
    whole    = WH_W'(fl) + WH_W'({1'b0, inc});
    ovf      = (whole > WH_MAX) || (whole < WH_MIN);
    if (ovf) begin
      scaled   = whole[WH_W-1] ? VAL_MIN : VAL_MAX;
      frac_new = '0;
    end else begin
      scaled   = whole[VAL_W-1:0];
      frac_new = {inc, low};
    end
  end

  always_comb begin
    out_free = !out_v || out_ready;
    stall    = pend_v && !out_free;
    kept_inc = (kept == KEPT_MAX) ? kept : kept + KEPT_W'(1);

    prod_item.out_present   = 1'b1;
    prod_item.out_batch_end = 1'b0;
    if (state == ST_FIX) begin
      prod_req            = !op_flush || (scaled != '0);
      prod_item.out_value = scaled;
      if (!op_flush) begin
        prod_item.out_offset   = head.ofs;
        prod_item.out_stamp    = head.stamp;
        prod_item.out_sequence = head.seq;
      end else if (op_y) begin
        prod_item.out_offset   = cfg.y_axis_offset;
        prod_item.out_stamp    = head.stamp_y;
        prod_item.out_sequence = head.seq_y;
      end else begin
        prod_item.out_offset   = cfg.x_axis_offset;
        prod_item.out_stamp    = head.stamp_x;
        prod_item.out_sequence = head.seq_x;
      end
    end else begin
      prod_req               = (state == ST_HEAD) && head_valid && (head.kind == KIND_PASS);
      prod_item.out_value    = head.val;
      prod_item.out_offset   = head.ofs;
      prod_item.out_stamp    = head.stamp;
      prod_item.out_sequence = head.seq;
    end
    prod_fire = prod_req && !stall;

    marker               = '0;
    marker.out_batch_end = 1'b1;

    end_go    = out_free || !(head.last || pend_v);
    pop_ready = (state == ST_END) && end_go;
  end

  // The newest result waits in pend until it is known whether it ends the batch.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_HEAD;
      frac_x <= '0;
      frac_y <= '0;
      kept   <= '0;
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (out_ready) begin
        out_v <= 1'b0;
      end

      if (prod_fire) begin
        if (pend_v) begin
          out_q <= pend;
          out_v <= 1'b1;
        end
        pend   <= prod_item;
        pend_v <= 1'b1;
        kept   <= kept_inc;
      end

      unique case (state)
        ST_HEAD: begin
          if (head_valid) begin
            unique case (head.kind)
              KIND_PASS: begin
                if (!stall) begin
                  state <= head.last ? ST_X : ST_END;
                end
              end
              KIND_SCALE_X, KIND_SCALE_Y: begin
                prod     <= mul_p;
                op_y     <= (head.kind == KIND_SCALE_Y);
                op_flush <= 1'b0;
                state    <= ST_FIX;
              end
              KIND_NONE: begin
                state <= ST_X;
              end
            endcase
          end
        end
        ST_FIX: begin
          if (!stall) begin
            if (op_y) begin
              frac_y <= frac_new;
            end else begin
              frac_x <= frac_new;
            end
            if (op_flush) begin
              state <= op_y ? ST_END : ST_Y;
            end else begin
              state <= head.last ? ST_X : ST_END;
            end
          end
        end
        ST_X: begin
          if (head.seen_x && (kept < cfg.batch_capacity)) begin
            prod     <= mul_p;
            op_y     <= 1'b0;
            op_flush <= 1'b1;
            state    <= ST_FIX;
          end else begin
            state <= ST_Y;
          end
        end
        ST_Y: begin
          if (head.seen_y && (kept < cfg.batch_capacity)) begin
            prod     <= mul_p;
            op_y     <= 1'b1;
            op_flush <= 1'b1;
            state    <= ST_FIX;
          end else begin
            state <= ST_END;
          end
        end
        ST_END: begin
          if (end_go) begin
            if (head.last) begin
              if (pend_v) begin
                out_q               <= pend;
                out_q.out_batch_end <= 1'b1;
              end else begin
                out_q <= marker;
              end
              out_v  <= 1'b1;
              pend_v <= 1'b0;
              kept   <= '0;
            end else if (pend_v) begin
              out_q  <= pend;
              out_v  <= 1'b1;
              pend_v <= 1'b0;
            end
            state <= ST_HEAD;
          end
        end
        default: begin
          state <= ST_HEAD;
        end
      endcase
    end
  end

  assign out_valid = out_v;
  assign out_data  = out_q;

endmodule

// ===== rtl/mouse_delta_coalesce_scale_core.sv =====
// Mouse delta coalesce and scale block: configuration registers, front end, job queue, back end.
//
// Events enter on in_ch and results leave on out_ch, both valid/ready. The front end takes one
// event per cycle while the job queue has room; coalesced X and Y events in mid-batch are not
// queued and reach the back end only through the batch end. The back end works on one job at a
// time and pops it only on leaving ST_END. A pass-through event goes from ST_HEAD to ST_END, an
// event scaled in place is multiplied, truncated and released (ST_HEAD, ST_FIX, ST_END), and for
// the last event of a batch ST_X and ST_Y come before ST_END, each flushed axis via ST_FIX. The
// single multiplier in the back end is shared by in-place scaling and both flushes. A result is
// held back by one step until it is known whether it closes the batch; a batch that yields
// nothing closes with an empty marker. Configuration registers are written through cfg_write,
// cfg_index and cfg_data and must only change while no event is in flight.
module mouse_delta_coalesce_scale_core import mdcs_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  mdcs_in_if.sink                in_ch,
  mdcs_out_if.source             out_ch,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coalesce_enable <= RST_COALESCE;
      cfg.multiplier_x    <= RST_MULT;
      cfg.multiplier_y    <= RST_MULT;
      cfg.x_axis_offset   <= RST_X_OFS;
      cfg.y_axis_offset   <= RST_Y_OFS;
      cfg.x_axis_present  <= RST_X_PRES;
      cfg.y_axis_present  <= RST_Y_PRES;
      cfg.batch_capacity  <= RST_CAPACITY;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COALESCE_ENABLE: cfg.coalesce_enable <= cfg_data[0];
        REG_MULTIPLIER_X:    cfg.multiplier_x    <= cfg_data[MULT_W-1:0];
        REG_MULTIPLIER_Y:    cfg.multiplier_y    <= cfg_data[MULT_W-1:0];
        REG_X_AXIS_OFFSET:   cfg.x_axis_offset   <= cfg_data[OFS_W-1:0];
        REG_Y_AXIS_OFFSET:   cfg.y_axis_offset   <= cfg_data[OFS_W-1:0];
        REG_X_AXIS_PRESENT:  cfg.x_axis_present  <= cfg_data[0];
        REG_Y_AXIS_PRESENT:  cfg.y_axis_present  <= cfg_data[0];
        REG_BATCH_CAPACITY:  cfg.batch_capacity  <= cfg_data[KEPT_W-1:0];
      endcase
    end
  end

  mdcs_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_data    (in_ch.data),
    .in_ready   (in_ch.ready),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  mdcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  mdcs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (pop_valid),
    .head       (pop_job),
    .pop_ready  (pop_ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_ch.data),
    .out_ready  (out_ch.ready)
  );

endmodule

// ===== tb/sv/tb_mouse_delta_coalesce_scale_core.sv =====
// Self-checking testbench of the mouse delta coalesce and scale core.
module tb_mouse_delta_coalesce_scale_core import mdcs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     QUIET_LIMIT   = 4000;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     PHASES        = 6;
  localparam int     PHASE_EVENTS  = 70;
  localparam longint DELTA_MAX     = 64'sd2147483647;
  localparam longint DELTA_MIN     = -64'sd2147483648;
  localparam logic [MULT_W-1:0] GAIN_ONE = MULT_W'(1) << FRAC_BITS_DEFAULT;
  localparam logic [MULT_W-1:0] GAIN_TOP = 23'd6553600;

  class delta_scoreboard;
    cfg_t               cfg;
    longint             frac_x, frac_y, sum_x, sum_y;
    bit                 seen_x, seen_y;
    logic [STAMP_W-1:0] stamp_x, seq_x, stamp_y, seq_y;
    logic [KEPT_W-1:0]  kept;
    out_item_t          step_events[$];
    out_item_t          pending_events[$];
    int unsigned        mismatch_count;

    function new();
      cfg.coalesce_enable = RST_COALESCE;
      cfg.multiplier_x    = RST_MULT;
      cfg.multiplier_y    = RST_MULT;
      cfg.x_axis_offset   = RST_X_OFS;
      cfg.y_axis_offset   = RST_Y_OFS;
      cfg.x_axis_present  = RST_X_PRES;
      cfg.y_axis_present  = RST_Y_PRES;
      cfg.batch_capacity  = RST_CAPACITY;
      stamp_x = '0;
      seq_x   = '0;
      stamp_y = '0;
      seq_y   = '0;
      kept    = '0;
    endfunction

    function longint clamp32(longint v);
      if (v > DELTA_MAX) return DELTA_MAX;
      if (v < DELTA_MIN) return DELTA_MIN;
      return v;
    endfunction

    // Multiplies by the axis gain, truncates toward zero and keeps the exact
    // remainder for the next use of that axis, or clears it when the result saturates.
    function longint scale_delta(longint delta, bit on_y);
      longint gain, total, whole;
      gain  = on_y ? cfg.multiplier_y : cfg.multiplier_x;
      total = delta * gain + (on_y ? frac_y : frac_x);
      whole = (total < 0 ? -total : total) >>> FRAC_BITS_DEFAULT;
      if (total < 0) whole = -whole;
      if (whole > DELTA_MAX || whole < DELTA_MIN) begin
        if (on_y) frac_y = 0;
        else frac_x = 0;
        return clamp32(whole);
      end
      if (on_y) frac_y = total - (whole <<< FRAC_BITS_DEFAULT);
      else frac_x = total - (whole <<< FRAC_BITS_DEFAULT);
      return whole;
    endfunction

    function void add_event(logic [OFS_W-1:0] ofs, longint value,
                            logic [STAMP_W-1:0] stamp, logic [STAMP_W-1:0] seq);
      out_item_t r;
      r.out_offset    = ofs;
      r.out_value     = value[VAL_W-1:0];
      r.out_stamp     = stamp;
      r.out_sequence  = seq;
      r.out_present   = 1'b1;
      r.out_batch_end = 1'b0;
      step_events.push_back(r);
      if (kept < KEPT_MAX) kept++;
    endfunction

    function void note_event(in_item_t item);
      longint    value, delta;
      bit        mx, my, scaling;
      out_item_t closing;
      value = $signed(item.event_value);
      mx = cfg.x_axis_present && item.event_offset == cfg.x_axis_offset;
      my = !mx && cfg.y_axis_present && item.event_offset == cfg.y_axis_offset;
      if (cfg.coalesce_enable) begin
        if (mx) begin
          sum_x   = clamp32(sum_x + value);
          seen_x  = 1'b1;
          stamp_x = item.time_stamp;
          seq_x   = item.sequence_number;
        end else if (my) begin
          sum_y   = clamp32(sum_y + value);
          seen_y  = 1'b1;
          stamp_y = item.time_stamp;
          seq_y   = item.sequence_number;
        end else begin
          add_event(item.event_offset, value, item.time_stamp, item.sequence_number);
        end
      end else begin
        // With both gains at unity the remainders stay untouched.
        scaling = cfg.multiplier_x != GAIN_ONE || cfg.multiplier_y != GAIN_ONE;
        delta   = value;
        if (scaling && mx) delta = scale_delta(value, 1'b0);
        else if (scaling && my) delta = scale_delta(value, 1'b1);
        add_event(item.event_offset, delta, item.time_stamp, item.sequence_number);
      end
      if (item.batch_last) begin
        if (seen_x && kept < cfg.batch_capacity) begin
          delta = scale_delta(sum_x, 1'b0);
          if (delta != 0) add_event(cfg.x_axis_offset, delta, stamp_x, seq_x);
        end
        if (seen_y && kept < cfg.batch_capacity) begin
          delta = scale_delta(sum_y, 1'b1);
          if (delta != 0) add_event(cfg.y_axis_offset, delta, stamp_y, seq_y);
        end
        if (step_events.size() == 0) begin
          closing = '0;
        end else begin
          closing = step_events.pop_back();
        end
        closing.out_batch_end = 1'b1;
        step_events.push_back(closing);
        sum_x  = 0;
        sum_y  = 0;
        seen_x = 1'b0;
        seen_y = 1'b0;
        kept   = '0;
      end
      while (step_events.size() != 0) pending_events.push_back(step_events.pop_front());
    endfunction

    function string show(out_item_t r);
      return $sformatf("ofs=%0d value=%0d stamp=%h seq=%h present=%b end=%b",
                       r.out_offset, r.out_value, r.out_stamp, r.out_sequence,
                       r.out_present, r.out_batch_end);
    endfunction

    function void report_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        report_failure({"result with nothing expected: ", show(got)});
      end else begin
        want = pending_events.pop_front();
        if (got.out_offset !== want.out_offset || got.out_value !== want.out_value ||
            got.out_stamp !== want.out_stamp || got.out_sequence !== want.out_sequence ||
            got.out_present !== want.out_present ||
            got.out_batch_end !== want.out_batch_end) begin
          report_failure({"expected ", show(want), " got ", show(got)});
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     idle_pct     = 0;
  int                     stall_pct    = 0;
  int                     hold_off     = 0;
  int                     quiet_cycles = 0;
  delta_scoreboard        sb = new();

  mdcs_in_if  in_ch ();
  mdcs_out_if out_ch ();

  mouse_delta_coalesce_scale_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off counted here when requested.
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_ch.valid && out_ch.ready) sb.check_event(out_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_event(in_ch.data);
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_event(in_item_t item);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Waits until every predicted result has arrived and the back end has settled.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_config(cfg_t c);
    drain();
    write_reg(REG_COALESCE_ENABLE, CFG_DATA_W'(c.coalesce_enable));
    write_reg(REG_MULTIPLIER_X, c.multiplier_x);
    write_reg(REG_MULTIPLIER_Y, c.multiplier_y);
    write_reg(REG_X_AXIS_OFFSET, CFG_DATA_W'(c.x_axis_offset));
    write_reg(REG_Y_AXIS_OFFSET, CFG_DATA_W'(c.y_axis_offset));
    write_reg(REG_X_AXIS_PRESENT, CFG_DATA_W'(c.x_axis_present));
    write_reg(REG_Y_AXIS_PRESENT, CFG_DATA_W'(c.y_axis_present));
    write_reg(REG_BATCH_CAPACITY, CFG_DATA_W'(c.batch_capacity));
    cfg_write <= 1'b0;
    sb.cfg = c;
  endtask

  function automatic in_item_t make_event(logic [OFS_W-1:0] ofs, int value, bit last);
    in_item_t item;
    item.event_offset    = ofs;
    item.event_value     = value;
    item.time_stamp      = $urandom;
    item.sequence_number = $urandom;
    item.batch_last      = last;
    return item;
  endfunction

  function automatic in_item_t random_event(bit last);
    in_item_t item;
    item = make_event(8'($urandom_range(255)), int'($urandom_range(400)) - 200, last);
    case ($urandom_range(9))
      0, 1, 2, 3: item.event_offset = sb.cfg.x_axis_offset;
      4, 5, 6:    item.event_offset = sb.cfg.y_axis_offset;
      default:    ;
    endcase
    case ($urandom_range(7))
      0:       item.event_value = $urandom;
      1:       item.event_value = VAL_MAX;
      2:       item.event_value = VAL_MIN;
      3:       item.event_value = '0;
      default: ;
    endcase
    return item;
  endfunction

  function automatic logic [MULT_W-1:0] random_gain();
    case ($urandom_range(4))
      0:       return GAIN_ONE;
      1:       return 23'd1;
      2:       return GAIN_TOP;
      3:       return 23'($urandom_range(1, 6553600));
      default: return 23'($urandom_range(16384, 196608));
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.coalesce_enable = 1'b1;
    c.multiplier_x    = random_gain();
    c.multiplier_y    = random_gain();
    c.x_axis_offset   = 8'($urandom_range(255));
    c.y_axis_offset   = ($urandom_range(9) == 0) ? c.x_axis_offset : 8'($urandom_range(255));
    c.x_axis_present  = ($urandom_range(9) != 0);
    c.y_axis_present  = ($urandom_range(9) != 0);
    case ($urandom_range(7))
      0:       c.batch_capacity = '0;
      1:       c.batch_capacity = 16'd1;
      2:       c.batch_capacity = 16'hFFFF;
      3:       c.batch_capacity = RST_CAPACITY;
      default: c.batch_capacity = 16'($urandom_range(2, 4));
    endcase
    return c;
  endfunction

  initial begin : stimulus
    cfg_t     c;
    in_item_t ev;
    int       p, k, len, count;
    bit       paused;
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: sums saturate, other codes pass through at once.
    send_event(make_event(RST_X_OFS, 5, 1'b0));
    send_event(make_event(RST_Y_OFS, -3, 1'b0));
    send_event(make_event(8'd8, 1, 1'b0));
    send_event(make_event(RST_X_OFS, VAL_MAX, 1'b0));
    send_event(make_event(RST_X_OFS, 10, 1'b1));
    ev = make_event(8'hFF, VAL_MIN, 1'b1);
    ev.time_stamp      = '1;
    ev.sequence_number = '0;
    send_event(ev);
    send_event(make_event(RST_X_OFS, 0, 1'b1));
    send_event(make_event(RST_Y_OFS, VAL_MIN, 1'b0));
    send_event(make_event(RST_Y_OFS, -1, 1'b1));

    // Largest X gain overflows; smallest Y gain leaves only a remainder.
    c = sb.cfg;
    c.multiplier_x = GAIN_TOP;
    c.multiplier_y = 23'd1;
    set_config(c);
    send_event(make_event(RST_X_OFS, VAL_MAX, 1'b1));
    send_event(make_event(RST_Y_OFS, 3, 1'b1));
    send_event(make_event(RST_X_OFS, -1, 1'b1));

    c.coalesce_enable = 1'b0;
    c.multiplier_x    = GAIN_ONE;
    c.multiplier_y    = GAIN_ONE;
    set_config(c);
    send_event(make_event(RST_X_OFS, 9, 1'b0));
    send_event(make_event(RST_Y_OFS, -9, 1'b1));

    c.multiplier_x = 23'd98304;
    set_config(c);
    send_event(make_event(RST_X_OFS, 3, 1'b0));
    send_event(make_event(RST_X_OFS, 3, 1'b0));
    send_event(make_event(RST_Y_OFS, 7, 1'b1));

    // The mode changes in mid-batch; the held X sum is flushed at the end anyway.
    c.coalesce_enable = 1'b1;
    set_config(c);
    send_event(make_event(RST_X_OFS, 7, 1'b0));
    c.coalesce_enable = 1'b0;
    set_config(c);
    send_event(make_event(RST_X_OFS, 2, 1'b1));

    c.coalesce_enable = 1'b1;
    c.multiplier_x    = GAIN_ONE;
    c.batch_capacity  = 16'd1;
    set_config(c);
    send_event(make_event(8'd8, 1, 1'b0));
    send_event(make_event(RST_X_OFS, 4, 1'b0));
    send_event(make_event(RST_Y_OFS, 4, 1'b1));

    c.batch_capacity = '0;
    set_config(c);
    send_event(make_event(RST_X_OFS, 5, 1'b1));

    c.batch_capacity = RST_CAPACITY;
    c.x_axis_present = 1'b0;
    c.y_axis_present = 1'b0;
    set_config(c);
    send_event(make_event(RST_X_OFS, 5, 1'b1));

    // Both axes on one offset: X wins.
    c.x_axis_present = 1'b1;
    c.y_axis_present = 1'b1;
    c.x_axis_offset  = 8'd17;
    c.y_axis_offset  = 8'd17;
    set_config(c);
    send_event(make_event(8'd17, 6, 1'b1));

    for (p = 0; p < PHASES; p++) begin
      c = random_config();
      c.coalesce_enable = (p % 2 == 0);
      set_config(c);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 66;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 66;
        end
        default: begin
          idle_pct  = 31;
          stall_pct = 31;
        end
      endcase
      // Results are held off while events keep coming, so the input backs up.
      if (p == 2) hold_off = 250;
      count  = 0;
      paused = 1'b0;
      while (count < PHASE_EVENTS) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) send_event(random_event(k == len - 1));
        count += len;
        if (p == 3 && !paused && count >= PHASE_EVENTS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    if (sb.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
